// ===== rtl/sorted_event_table_defines.svh =====
// assertion macros for the sorted event table
`ifndef SORTED_EVENT_TABLE_DEFINES_SVH
`define SORTED_EVENT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define SEVT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted_event_table check failed");
`define SEVT_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted_event_table check failed");
`else
`define SEVT_ASSERT_IMP(lbl, ante, cons)
`define SEVT_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/sevt_pkg.sv =====
package sevt_pkg;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  sh;
      logic [5:0]  sm;
      logic [4:0]  eh;
      logic [5:0]  em;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_BAD    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_CONFLICT  = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef struct packed {
      logic date_ok;
      logic start_ok;
      logic end_ok;
      logic key_gt;
      logic same_date;
      logic exact;
      logic prev_overlap;
      logic next_overlap;
   } cmp_type;

   localparam logic [11:0] YEAR_MIN = 12'd2025;
   localparam logic [11:0] YEAR_MAX = 12'd2100;
   localparam logic [3:0]  MONTH_MAX = 4'd12;
   localparam logic [4:0]  HOUR_MAX = 5'd23;
   localparam logic [5:0]  MINUTE_MAX = 6'd59;

   function automatic logic [4:0] month_days(input logic [3:0] month);
      logic [4:0] d;
      case (month)
         4'd2: d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/sorted_event_table.sv =====
// channel   direction  transfer when
// req_*     in         req_valid & req_ready
// rsp_*     out        rsp_valid & rsp_ready
//
// one command at a time through one compare unit and one ram read port
// busy after the transfer until the command is done; each ram read takes an address
// step (SCAN_RD or SHIFT_RD) and then a registered data step (SCAN_EV or SHIFT_EV)
// a query emits one transfer per match, or one not-found transfer when none match;
// the scan waits while the output register is full
// the output register lets a new command in while the last result waits
// reset empties the table at once
module sorted_event_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_year,
   input  logic [3:0]  req_month,
   input  logic [4:0]  req_day,
   input  logic [4:0]  req_start_hour,
   input  logic [5:0]  req_start_minute,
   input  logic [4:0]  req_end_hour,
   input  logic [5:0]  req_end_minute,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_position,
   output logic [11:0] rsp_found_year,
   output logic [3:0]  rsp_found_month,
   output logic [4:0]  rsp_found_day,
   output logic [4:0]  rsp_found_start_hour,
   output logic [5:0]  rsp_found_start_minute,
   output logic [4:0]  rsp_found_end_hour,
   output logic [5:0]  rsp_found_end_minute,
   output logic        rsp_last
);

`include "sorted_event_table_defines.svh"

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
   localparam int EW = $bits(sevt_pkg::entry_type);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_CHECK    = 7'b0000010,
      S_SCAN_RD  = 7'b0000100,
      S_SCAN_EV  = 7'b0001000,
      S_SHIFT_RD = 7'b0010000,
      S_SHIFT_EV = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   typedef struct packed {
      sevt_pkg::status_type status;
      logic [CW-1:0]        pos;
      sevt_pkg::entry_type  ent;
      logic                 last;
   } res_type;

   function automatic res_type err_res(input sevt_pkg::status_type s);
      res_type r;
      r.status = s;
      r.pos = '0;
      r.ent = '0;
      r.last = 1'b1;
      return r;
   endfunction

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [CW-1:0] cnt_ff, cnt_in, idx_ff, idx_in, j_ff, j_in, pos_ff, pos_in;
   logic [CW-1:0] pend_idx_ff, pend_idx_in;
   sevt_pkg::cmd_type cmd_ff, cmd_in;
   sevt_pkg::entry_type rq_ff, rq_in, pend_ent_ff, pend_ent_in;
   logic prev_conf_ff, prev_conf_in, pend_vld_ff, pend_vld_in;
   res_type res_ff, res_in, out_ff, out_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   sevt_pkg::entry_type st_ent;
   sevt_pkg::cmp_type c;
   logic [CW+4:0] pos_wide;

   assign st_ent = sevt_pkg::entry_type'(ram_rdata);

   sevt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sevt_cmp u_cmp (
      .rq  (rq_ff),
      .st  (st_ent),
      .res (c)
   );

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      j_in = j_ff;
      pos_in = pos_ff;
      pend_idx_in = pend_idx_ff;
      pend_ent_in = pend_ent_ff;
      pend_vld_in = pend_vld_ff;
      prev_conf_in = prev_conf_ff;
      cmd_in = cmd_ff;
      rq_in = rq_ff;
      res_in = res_ff;
      out_in = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ram_we = 1'b0;
      ram_waddr = j_ff[AW-1:0];
      ram_wdata = ram_rdata;
      ram_raddr = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in = sevt_pkg::cmd_type'(req_cmd);
               rq_in.year = req_year;
               rq_in.month = req_month;
               rq_in.day = req_day;
               rq_in.sh = req_start_hour;
               rq_in.sm = req_start_minute;
               rq_in.eh = req_end_hour;
               rq_in.em = req_end_minute;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in = '0;
            prev_conf_in = 1'b0;
            pend_vld_in = 1'b0;
            ret_in = S_IDLE;
            state_in = S_SCAN_RD;
            case (cmd_ff)
               sevt_pkg::CMD_INSERT: begin
                  if (!(c.date_ok && c.start_ok && c.end_ok)) begin
                     res_in = err_res(sevt_pkg::ST_INVALID);
                     state_in = S_RESP;
                  end
               end
               sevt_pkg::CMD_REMOVE, sevt_pkg::CMD_QUERY: begin
                  if (cnt_ff == '0) begin
                     res_in = err_res(sevt_pkg::ST_EMPTY);
                     state_in = S_RESP;
                  end else if (!c.date_ok ||
                               (cmd_ff == sevt_pkg::CMD_REMOVE && !c.start_ok)) begin
                     res_in = err_res(sevt_pkg::ST_INVALID);
                     state_in = S_RESP;
                  end
               end
               default: begin
                  res_in = err_res(sevt_pkg::ST_INVALID);
                  state_in = S_RESP;
               end
            endcase
         end
         S_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               ret_in = S_IDLE;
               state_in = S_RESP;
               case (cmd_ff)
                  sevt_pkg::CMD_INSERT: begin
                     if (prev_conf_ff) begin
                        res_in = err_res(sevt_pkg::ST_CONFLICT);
                     end else if (cnt_ff == DEPTH_C) begin
                        res_in = err_res(sevt_pkg::ST_FULL);
                     end else begin
                        pos_in = idx_ff;
                        j_in = cnt_ff;
                        state_in = S_SHIFT_RD;
                     end
                  end
                  sevt_pkg::CMD_QUERY: begin
                     if (pend_vld_ff) begin
                        res_in.status = sevt_pkg::ST_OK;
                        res_in.pos = pend_idx_ff;
                        res_in.ent = pend_ent_ff;
                        res_in.last = 1'b1;
                     end else begin
                        res_in = err_res(sevt_pkg::ST_NOT_FOUND);
                     end
                  end
                  default: begin
                     res_in = err_res(sevt_pkg::ST_NOT_FOUND);
                  end
               endcase
            end else begin
               state_in = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            idx_in = idx_ff + CW'(1);
            state_in = S_SCAN_RD;
            case (cmd_ff)
               sevt_pkg::CMD_INSERT: begin
                  if (c.key_gt) begin
                     ret_in = S_IDLE;
                     if (prev_conf_ff || c.next_overlap) begin
                        res_in = err_res(sevt_pkg::ST_CONFLICT);
                        state_in = S_RESP;
                     end else if (cnt_ff == DEPTH_C) begin
                        res_in = err_res(sevt_pkg::ST_FULL);
                        state_in = S_RESP;
                     end else begin
                        pos_in = idx_ff;
                        j_in = cnt_ff;
                        state_in = S_SHIFT_RD;
                     end
                  end else begin
                     prev_conf_in = c.prev_overlap;
                  end
               end
               sevt_pkg::CMD_REMOVE: begin
                  if (c.exact) begin
                     pos_in = idx_ff;
                     j_in = idx_ff;
                     state_in = S_SHIFT_RD;
                  end
               end
               default: begin
                  if (c.same_date) begin
                     pend_vld_in = 1'b1;
                     pend_idx_in = idx_ff;
                     pend_ent_in = st_ent;
                     if (pend_vld_ff) begin
                        res_in.status = sevt_pkg::ST_OK;
                        res_in.pos = pend_idx_ff;
                        res_in.ent = pend_ent_ff;
                        res_in.last = 1'b0;
                        ret_in = S_SCAN_RD;
                        state_in = S_RESP;
                     end
                  end
               end
            endcase
         end
         S_SHIFT_RD: begin
            if (cmd_ff == sevt_pkg::CMD_INSERT) begin
               ram_raddr = AW'(j_ff - CW'(1));
               if (j_ff == pos_ff) begin
                  ram_we = 1'b1;
                  ram_waddr = pos_ff[AW-1:0];
                  ram_wdata = rq_ff;
                  cnt_in = cnt_ff + CW'(1);
                  res_in = err_res(sevt_pkg::ST_OK);
                  res_in.pos = pos_ff;
                  ret_in = S_IDLE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SHIFT_EV;
               end
            end else begin
               ram_raddr = AW'(j_ff + CW'(1));
               if (j_ff + CW'(1) == cnt_ff) begin
                  cnt_in = cnt_ff - CW'(1);
                  res_in = err_res(sevt_pkg::ST_OK);
                  res_in.pos = pos_ff;
                  ret_in = S_IDLE;
                  state_in = S_RESP;
               end else begin
                  state_in = S_SHIFT_EV;
               end
            end
         end
         S_SHIFT_EV: begin
            ram_we = 1'b1;
            state_in = S_SHIFT_RD;
            if (cmd_ff == sevt_pkg::CMD_INSERT) begin
               j_in = j_ff - CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_in = res_ff;
               rsp_valid_in = 1'b1;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ret_ff <= ret_in;
      idx_ff <= idx_in;
      j_ff <= j_in;
      pos_ff <= pos_in;
      pend_idx_ff <= pend_idx_in;
      pend_ent_ff <= pend_ent_in;
      pend_vld_ff <= pend_vld_in;
      prev_conf_ff <= prev_conf_in;
      cmd_ff <= cmd_in;
      rq_ff <= rq_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign pos_wide = {5'd0, out_ff.pos};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_position = pos_wide[4:0];
   assign rsp_found_year = out_ff.ent.year;
   assign rsp_found_month = out_ff.ent.month;
   assign rsp_found_day = out_ff.ent.day;
   assign rsp_found_start_hour = out_ff.ent.sh;
   assign rsp_found_start_minute = out_ff.ent.sm;
   assign rsp_found_end_hour = out_ff.ent.eh;
   assign rsp_found_end_minute = out_ff.ent.em;
   assign rsp_last = out_ff.last;

   `SEVT_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_ff <= DEPTH_C)
   `SEVT_ASSERT_NXT(a_accept_check, req_valid && req_ready, state_ff == S_CHECK)
   `SEVT_ASSERT_IMP(a_we_shift, ram_we, state_ff == S_SHIFT_RD || state_ff == S_SHIFT_EV)
   `SEVT_ASSERT_IMP(a_scan_idx, state_ff == S_SCAN_RD || state_ff == S_SCAN_EV, idx_ff <= cnt_ff)

endmodule

// ===== rtl/sevt_ram.sv =====
module sevt_ram #(
   parameter int WIDTH = 43,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sevt_cmp.sv =====
module sevt_cmp (
   input  sevt_pkg::entry_type rq,
   input  sevt_pkg::entry_type st,
   output sevt_pkg::cmp_type   res
);

   always_comb begin
      res.date_ok = (rq.year >= sevt_pkg::YEAR_MIN) && (rq.year <= sevt_pkg::YEAR_MAX) &&
                    (rq.month != 4'd0) && (rq.month <= sevt_pkg::MONTH_MAX) &&
                    (rq.day != 5'd0) && (rq.day <= sevt_pkg::month_days(rq.month));
      res.start_ok = (rq.sh <= sevt_pkg::HOUR_MAX) && (rq.sm <= sevt_pkg::MINUTE_MAX);
      res.end_ok = (rq.eh <= sevt_pkg::HOUR_MAX) && (rq.em <= sevt_pkg::MINUTE_MAX) &&
                   ({rq.eh, rq.em} >= {rq.sh, rq.sm});
      res.key_gt = {st.year, st.month, st.day, st.sh, st.sm} >
                   {rq.year, rq.month, rq.day, rq.sh, rq.sm};
      res.same_date = (st.year == rq.year) && (st.month == rq.month) && (st.day == rq.day);
      res.exact = res.same_date && (st.sh == rq.sh) && (st.sm == rq.sm);
      res.prev_overlap = res.same_date && ({st.eh, st.em} > {rq.sh, rq.sm});
      res.next_overlap = res.same_date && ({rq.eh, rq.em} > {st.sh, st.sm});
   end

endmodule
